FILE: rtl/capp_pkg.sv
`default_nettype none

package capp_pkg;

	localparam logic [7:0] SYNC_BYTE  = 8'hFF;
	localparam logic [7:0] BCAST_ID   = 8'hFE;
	localparam logic [7:0] GOOD_SUM   = 8'hFF;

	localparam logic [1:0] REG_OWN_ID         = 2'd0;
	localparam logic [1:0] REG_BULK_WAIT      = 2'd1;
	localparam logic [1:0] REG_BULK_FOLLOW_ID = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_HDR0    = 3'd1,
		ST_HDR1    = 3'd2,
		ST_GOTID   = 3'd3,
		ST_GOTLEN  = 3'd4,
		ST_PAYLOAD = 3'd5
	} stage_t;

	typedef enum logic [2:0] {
		V_NONE   = 3'd0,
		V_CSUM   = 3'd1,
		V_DIRECT = 3'd2,
		V_BCAST  = 3'd3,
		V_BULK   = 3'd4,
		V_NOADDR = 3'd5
	} verdict_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       frame_end;
		verdict_t   verdict;
		logic [7:0] frame_id;
		logic       watchdog_clear;
	} result_t;

	typedef struct packed {
		logic       we;
		logic [1:0] index;
		logic [7:0] data;
	} cfg_wr_t;

endpackage

`default_nettype wire

FILE: rtl/checksummed_addressed_packet_parser.sv
// channel  | dir | signals                                   | beat when
// ---------+-----+-------------------------------------------+----------------------
// in       | in  | in_valid, in_ready, rx_byte               | in_valid & in_ready
// out      | out | out_valid, out_ready, payload_*, frame_*, | out_valid & out_ready
//          |     | verdict, watchdog_clear                   |
// cfg      | in  | cfg_we, cfg_index, cfg_data               | cfg_we
//
// One byte per cycle sustained while out_ready is high; a result is presented from the
// result register, after its input beat has passed the input register and the parser.
// Input register feeds the parser state machine; the result register holds one beat.
// in_ready drops only while both registers are full and out_ready is low.
// Reset brings the parser to idle and the registers to own_id 1, others zero.
`default_nettype none

module checksummed_addressed_packet_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            payload_valid,
	output logic [7:0]      payload_byte,
	output logic [7:0]      payload_index,
	output logic            frame_end,
	output logic [2:0]      verdict,
	output logic [7:0]      frame_id,
	output logic            watchdog_clear,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              take;
	capp_pkg::cfg_wr_t cfg;
	capp_pkg::result_t res, res_s2;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	capp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	capp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (take),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	capp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign payload_valid  = res_s2.payload_valid;
	assign payload_byte   = res_s2.payload_byte;
	assign payload_index  = res_s2.payload_index;
	assign frame_end      = res_s2.frame_end;
	assign verdict        = 3'(res_s2.verdict);
	assign frame_id       = res_s2.frame_id;
	assign watchdog_clear = res_s2.watchdog_clear;

endmodule

`default_nettype wire

FILE: rtl/capp_in_reg.sv
`default_nettype none

module capp_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// slot frees when the core takes the held beat this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/capp_core.sv
`default_nettype none

module capp_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire capp_pkg::cfg_wr_t cfg,
	input  wire logic              step,
	input  wire logic [7:0]        byte_s1,
	output capp_pkg::result_t      res
);

	capp_pkg::stage_t stage_q, stage_d;
	logic [7:0] own_id_q, follow_id_q;
	logic       bulk_wait_q;
	logic [7:0] sum_q, sum_d, id_q, id_d, len_q, len_d, ptr_q, ptr_d;
	logic       top_bit_q, top_bit_d;
	logic [7:0] sum_add, ptr_cur, ptr_inc;
	logic       first_top;
	logic       in_payload;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= 8'd1;
			bulk_wait_q <= 1'b0;
			follow_id_q <= 8'd0;
		end else if (cfg.we) begin
			case (cfg.index)
				capp_pkg::REG_OWN_ID:         own_id_q    <= cfg.data;
				capp_pkg::REG_BULK_WAIT:      bulk_wait_q <= cfg.data[0];
				capp_pkg::REG_BULK_FOLLOW_ID: follow_id_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign in_payload = (stage_q == capp_pkg::ST_GOTLEN) || (stage_q == capp_pkg::ST_PAYLOAD);
	assign sum_add    = sum_q + byte_s1;
	assign ptr_cur    = (stage_q == capp_pkg::ST_GOTLEN) ? 8'd0 : ptr_q;
	assign ptr_inc    = ptr_cur + 8'd1;
	assign first_top  = (ptr_cur == 8'd0) ? byte_s1[7] : top_bit_q;

	// next state
	always_comb begin
		stage_d   = stage_q;
		sum_d     = sum_q;
		id_d      = id_q;
		len_d     = len_q;
		ptr_d     = ptr_q;
		top_bit_d = top_bit_q;
		case (stage_q)
			capp_pkg::ST_HDR0: begin
				if (byte_s1 == capp_pkg::SYNC_BYTE) begin
					stage_d = capp_pkg::ST_HDR1;
					sum_d   = 8'd0;
				end else begin
					stage_d = capp_pkg::ST_IDLE;
				end
			end
			capp_pkg::ST_HDR1: begin
				id_d    = byte_s1;
				sum_d   = sum_add;
				stage_d = capp_pkg::ST_GOTID;
			end
			capp_pkg::ST_GOTID: begin
				len_d   = byte_s1;
				sum_d   = sum_add;
				stage_d = capp_pkg::ST_GOTLEN;
			end
			capp_pkg::ST_GOTLEN, capp_pkg::ST_PAYLOAD: begin
				sum_d     = sum_add;
				ptr_d     = ptr_inc;
				top_bit_d = first_top;
				// zero length wraps the pointer: 256 payload bytes
				stage_d   = (ptr_inc == len_q) ? capp_pkg::ST_IDLE : capp_pkg::ST_PAYLOAD;
			end
			default: begin
				stage_d = (byte_s1 == capp_pkg::SYNC_BYTE) ? capp_pkg::ST_HDR0
				                                          : capp_pkg::ST_IDLE;
			end
		endcase
	end

	// result for this beat
	always_comb begin
		res                = '0;
		res.verdict        = capp_pkg::V_NONE;
		res.frame_id       = id_d;
		if (in_payload) begin
			res.payload_valid = 1'b1;
			res.payload_byte  = byte_s1;
			res.payload_index = ptr_cur;
			if (ptr_inc == len_q) begin
				res.frame_end = 1'b1;
				if (sum_add != capp_pkg::GOOD_SUM) begin
					res.verdict = capp_pkg::V_CSUM;
				end else if (id_q == own_id_q) begin
					res.verdict = capp_pkg::V_DIRECT;
				end else if (id_q == capp_pkg::BCAST_ID) begin
					res.verdict = capp_pkg::V_BCAST;
				end else if (bulk_wait_q && (id_q == follow_id_q) && first_top) begin
					res.verdict = capp_pkg::V_BULK;
				end else begin
					res.verdict = capp_pkg::V_NOADDR;
				end
			end
		end
		res.watchdog_clear = (res.verdict == capp_pkg::V_DIRECT) ||
		                     (res.verdict == capp_pkg::V_BCAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= capp_pkg::ST_IDLE;
			sum_q     <= 8'd0;
			id_q      <= 8'd0;
			len_q     <= 8'd0;
			ptr_q     <= 8'd0;
			top_bit_q <= 1'b0;
		end else if (step) begin
			stage_q   <= stage_d;
			sum_q     <= sum_d;
			id_q      <= id_d;
			len_q     <= len_d;
			ptr_q     <= ptr_d;
			top_bit_q <= top_bit_d;
		end
	end

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.frame_end |=> stage_q == capp_pkg::ST_IDLE)
		else $error("frame end did not return to idle");

	a_end_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res.frame_end |-> res.payload_valid && in_payload)
		else $error("frame end outside payload");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step && stage_q == capp_pkg::ST_HDR0 && byte_s1 == capp_pkg::SYNC_BYTE
		|=> sum_q == 8'd0 && stage_q == capp_pkg::ST_HDR1)
		else $error("sum not cleared on second sync byte");

	a_ptr_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step && stage_q == capp_pkg::ST_PAYLOAD && !res.frame_end
		|=> ptr_q == $past(ptr_q) + 8'd1)
		else $error("payload pointer skipped");

endmodule

`default_nettype wire

FILE: rtl/capp_out_reg.sv
`default_nettype none

module capp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire capp_pkg::result_t res,
	output logic                   take,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output capp_pkg::result_t      res_s2
);

	logic valid_s2;

	assign take      = valid_s1 && (!valid_s2 || out_ready);
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire
